[rtl/core/i2cmts_pkg.sv]
// Shared types and constants of the I2C master transfer sequencer.
package i2cmts_pkg;

    // Input item kinds (carried on s_tuser)
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_START  = 2'd1,
        OP_STATUS = 2'd2,
        OP_UNUSED = 2'd3
    } op_t;

    // Bus actions (carried on m_tuser)
    typedef enum logic [2:0] {
        ACT_NONE        = 3'd0,
        ACT_START_WRITE = 3'd1,
        ACT_START_READ  = 3'd2,
        ACT_SEND        = 3'd3,
        ACT_ACK_READ    = 3'd4,
        ACT_NACK_STOP   = 3'd5
    } bus_action_t;

    // Configuration register indexes
    localparam logic [2:0] CFG_MODE        = 3'd0;
    localparam logic [2:0] CFG_TARGET_ADDR = 3'd1;
    localparam logic [2:0] CFG_FIRST_LEN   = 3'd2;
    localparam logic [2:0] CFG_SECOND_LEN  = 3'd3;
    localparam logic [2:0] CFG_READ_LEN    = 3'd4;
    localparam logic [2:0] CFG_READ_WANTED = 3'd5;

    // Controller status bits
    localparam logic [7:0] ST_READ_FLAG  = 8'h80;
    localparam logic [7:0] ST_WRITE_FLAG = 8'h40;
    localparam logic [7:0] ST_HOLD       = 8'h20;
    localparam logic [7:0] ST_ARB        = 8'h08;
    localparam logic [7:0] ST_BUSERR     = 8'h04;
    localparam logic [7:0] ST_OWNER      = 8'h02;
    localparam logic [7:0] ST_READ_OK    = ST_READ_FLAG | ST_HOLD | ST_OWNER;
    localparam logic [7:0] ST_WRITE_OK   = ST_WRITE_FLAG | ST_HOLD | ST_OWNER;

    // The read position counter saturates here
    localparam logic [8:0] POS_MAX = 9'h1FF;

    // Result fields held between pipeline stages
    typedef struct packed {
        bus_action_t action;
        logic [7:0]  bus_byte;
        logic        byte_from_store;
        logic        rx_valid;
        logic [7:0]  rx_index;
        logic [7:0]  rx_byte;
        logic        busy;
        logic        ok;
    } result_t;

endpackage

[rtl/core/i2cmts_wstore.sv]
// Write byte store: one write port, one registered read port.
module i2cmts_wstore #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/i2c_master_transfer_sequencer_top.sv]
// A result passes the result stage register and then the output register after its
// request is accepted. Throughput: one request per cycle; the store read port answers in the
// cycle after the address goes in, which sets the two-stage result path.
// The input is held off only while both result stages are full and m_tready is low.
// Reset clears counters, flags, configuration and valid bits; the byte store is not
// cleared and holds unknown data until loaded.
module i2c_master_transfer_sequencer_top #(
    parameter int SEGMENT_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // bus_status[7:0], bus_rx_data[15:8], segment_select[16],
                                  // load_index[24:17], load_byte[32:25], zero[39:33]
    input  logic [1:0]  s_tuser,  // op[1:0]
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // bus_byte[7:0], rx_valid[8], rx_index[16:9],
                                  // rx_byte[24:17], busy_res[25], last_ok[26], zero[31:27]
    output logic [2:0]  m_tuser,  // bus_action[2:0]
    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);
    import i2cmts_pkg::*;

    localparam int STORE_DEPTH = 2 * SEGMENT_DEPTH;
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // Configuration registers
    logic       mode_reg;
    logic [6:0] target_addr_reg;
    logic [8:0] first_len_reg;
    logic [8:0] second_len_reg;
    logic [8:0] read_len_reg;
    logic       read_wanted_reg;

    // Transfer state
    logic [8:0] first_pos_reg, first_pos_next;
    logic [8:0] second_pos_reg, second_pos_next;
    logic [8:0] read_pos_reg, read_pos_next;
    logic       active_reg, active_next;
    logic       success_reg, success_next;

    // Pipeline
    logic    s1_valid_reg;
    result_t s1_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t res_next;

    // Request fields
    op_t        op;
    logic [7:0] bus_status;
    logic [7:0] bus_rx_data;
    logic       segment_select;
    logic [7:0] load_index;
    logic [7:0] load_byte;

    logic       in_accept;
    logic       s1_move;
    logic [7:0] addr8;
    logic [8:0] eff_first;
    logic [8:0] eff_second;
    logic [8:0] eff_read;
    logic       read_phase;
    logic       finish;
    logic       finish_ok;
    logic       wr_en;
    logic       rd_en;
    logic [31:0] wr_sum;
    logic [31:0] rd_sum;
    logic [7:0] store_rd_data;

    function automatic logic [8:0] clamp_len(input logic [8:0] n);
        logic [8:0] r;
        if (32'(n) > 32'(SEGMENT_DEPTH))
        begin
            r = 9'(SEGMENT_DEPTH);
        end
        else
        begin
            r = n;
        end
        return r;
    endfunction

    // Field unpacking
    assign op             = op_t'(s_tuser);
    assign bus_status     = s_tdata[7:0];
    assign bus_rx_data    = s_tdata[15:8];
    assign segment_select = s_tdata[16];
    assign load_index     = s_tdata[24:17];
    assign load_byte      = s_tdata[32:25];

    // Handshake: the result stage moves when the output register frees up
    assign s1_move   = !out_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || s1_move;
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Effective lengths, read live from configuration
    assign addr8      = {target_addr_reg, 1'b0};
    assign read_phase = !mode_reg && read_wanted_reg;
    assign eff_first  = clamp_len(first_len_reg);
    assign eff_second = mode_reg ? clamp_len(second_len_reg) : 9'd0;
    assign eff_read   = read_phase ? clamp_len(read_len_reg) : 9'd0;

    // Store addresses
    assign wr_sum = (segment_select ? 32'(SEGMENT_DEPTH) : 32'd0) + 32'(load_index);
    assign rd_sum = (first_pos_reg < eff_first) ? 32'(first_pos_reg)
                                                : 32'(SEGMENT_DEPTH) + 32'(second_pos_reg);

    // Request decode and state update
    always_comb
    begin
        first_pos_next  = first_pos_reg;
        second_pos_next = second_pos_reg;
        read_pos_next   = read_pos_reg;
        active_next     = active_reg;
        success_next    = success_reg;
        finish          = 1'b0;
        finish_ok       = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        res_next        = '0;
        res_next.action = ACT_NONE;

        if (in_accept)
        begin
            case (op)
                OP_LOAD:
                begin
                    wr_en = 32'(load_index) < 32'(SEGMENT_DEPTH);
                end
                OP_START:
                begin
                    if (!active_reg)
                    begin
                        first_pos_next  = '0;
                        second_pos_next = '0;
                        read_pos_next   = '0;
                        success_next    = 1'b0;
                        active_next     = 1'b1;
                        if (mode_reg || eff_first != 9'd0)
                        begin
                            res_next.action   = ACT_START_WRITE;
                            res_next.bus_byte = addr8;
                        end
                        else
                        begin
                            res_next.action   = ACT_START_READ;
                            res_next.bus_byte = addr8 | 8'h01;
                        end
                    end
                end
                OP_STATUS:
                begin
                    if (active_reg)
                    begin
                        if ((bus_status & (ST_ARB | ST_BUSERR)) != 8'h00)
                        begin
                            finish = 1'b1;
                        end
                        else if (bus_status == ST_READ_OK)
                        begin
                            res_next.rx_valid = 1'b1;
                            res_next.rx_index = read_pos_reg[7:0];
                            res_next.rx_byte  = bus_rx_data;
                            if (read_pos_reg != POS_MAX)
                            begin
                                read_pos_next = read_pos_reg + 9'd1;
                            end
                            if (read_pos_next < eff_read)
                            begin
                                res_next.action = ACT_ACK_READ;
                            end
                            else
                            begin
                                finish    = 1'b1;
                                finish_ok = 1'b1;
                            end
                        end
                        else if (bus_status == ST_WRITE_OK)
                        begin
                            if (first_pos_reg < eff_first)
                            begin
                                res_next.action          = ACT_SEND;
                                res_next.byte_from_store = 1'b1;
                                rd_en                    = 1'b1;
                                first_pos_next           = first_pos_reg + 9'd1;
                            end
                            else if (second_pos_reg < eff_second)
                            begin
                                res_next.action          = ACT_SEND;
                                res_next.byte_from_store = 1'b1;
                                rd_en                    = 1'b1;
                                second_pos_next          = second_pos_reg + 9'd1;
                            end
                            else if (read_phase)
                            begin
                                res_next.action   = ACT_START_READ;
                                res_next.bus_byte = addr8 | 8'h01;
                            end
                            else
                            begin
                                finish    = 1'b1;
                                finish_ok = 1'b1;
                            end
                        end
                        else
                        begin
                            finish = 1'b1;
                        end

                        if (finish)
                        begin
                            res_next.action   = ACT_NACK_STOP;
                            res_next.bus_byte = 8'h00;
                            success_next      = finish_ok;
                            active_next       = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        res_next.busy = active_next;
        res_next.ok   = success_next;
    end

    // Byte store
    i2cmts_wstore #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_wstore (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_sum[AW-1:0]),
        .wr_data (load_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_sum[AW-1:0]),
        .rd_data (store_rd_data)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= 1'b0;
            target_addr_reg <= '0;
            first_len_reg   <= '0;
            second_len_reg  <= '0;
            read_len_reg    <= '0;
            read_wanted_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg        <= cfg_data[0];
                CFG_TARGET_ADDR: target_addr_reg <= cfg_data[6:0];
                CFG_FIRST_LEN:   first_len_reg   <= cfg_data;
                CFG_SECOND_LEN:  second_len_reg  <= cfg_data;
                CFG_READ_LEN:    read_len_reg    <= cfg_data;
                CFG_READ_WANTED: read_wanted_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Transfer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pos_reg  <= '0;
            second_pos_reg <= '0;
            read_pos_reg   <= '0;
            active_reg     <= 1'b0;
            success_reg    <= 1'b0;
        end
        else
        begin
            first_pos_reg  <= first_pos_next;
            second_pos_reg <= second_pos_next;
            read_pos_reg   <= read_pos_next;
            active_reg     <= active_next;
            success_reg    <= success_next;
        end
    end

    // Result stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= in_accept;
            end
            if (s1_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Result stage payload; store data joins on the way to the output register
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_reg <= res_next;
        end
        if (s1_move && s1_valid_reg)
        begin
            out_reg <= s1_reg;
            if (s1_reg.byte_from_store)
            begin
                out_reg.bus_byte <= store_rd_data;
            end
        end
    end

    // Output packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.action;
    assign m_tdata  = {5'b0, out_reg.ok, out_reg.busy, out_reg.rx_byte, out_reg.rx_index,
                       out_reg.rx_valid, out_reg.bus_byte};

    // Checks
    a_rd_only_on_status: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (in_accept && op == OP_STATUS && active_reg))
        else $error("store read without an accepted status request");

    a_send_keeps_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ACT_SEND) |-> m_tdata[25])
        else $error("send action reported with busy low");

    a_stop_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ACT_NACK_STOP) |-> !m_tdata[25])
        else $error("stop action reported with busy high");

    a_rx_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[8]) |-> (m_tuser == ACT_ACK_READ || m_tuser == ACT_NACK_STOP))
        else $error("received byte delivered with wrong action");

    a_active_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(active_reg) |-> $past(in_accept && op == OP_START))
        else $error("transfer became active without a start request");

endmodule
